### rtl/core/meos_pkg.sv
// meos_pkg: shared types and constants for the midi event ordering sorter
// no dependencies
package meos_pkg;

  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_FLUSH  = 1'b1;

  typedef struct packed {
    logic        opcode;
    logic [31:0] event_time;
    logic [7:0]  status_byte;
    logic [7:0]  first_data;
    logic [7:0]  second_data;
    logic [3:0]  byte_count;
  } meos_in_t;

  typedef struct packed {
    logic [31:0] out_time;
    logic [7:0]  out_status;
    logic [7:0]  out_data1;
    logic [7:0]  out_data2;
    logic [1:0]  out_size;
    logic        is_last;
    logic        overflowed;
  } meos_out_t;

  typedef struct packed {
    logic [31:0] t;
    logic [7:0]  st;
    logic [7:0]  d1;
    logic [7:0]  d2;
  } meos_slot_t;

  localparam int SLOT_W = $bits(meos_slot_t);

  function automatic logic [4:0] class_rank(input logic [2:0] c);
    logic [4:0] r;
    case (c)
      3'd0: r = 5'd8;
      3'd1: r = 5'd9;
      3'd2: r = 5'd20;
      3'd3: r = 5'd4;
      3'd4: r = 5'd6;
      3'd5: r = 5'd16;
      3'd6: r = 5'd18;
      default: r = 5'd0;
    endcase
    return r;
  endfunction

  // time, rank, channel, first data byte
  function automatic logic [48:0] sort_key(input meos_slot_t s);
    return {s.t, class_rank(s.st[6:4]), s.st[3:0], s.d1};
  endfunction

  function automatic logic [1:0] msg_size(input logic [7:0] st);
    logic [1:0] r;
    case (st[7:4])
      4'hC, 4'hD: r = 2'd2;
      4'hF: begin
        if (st == 8'hF1 || st == 8'hF3) r = 2'd2;
        else if (st == 8'hF2) r = 2'd3;
        else r = 2'd1;
      end
      default: r = st[7] ? 2'd3 : 2'd0;
    endcase
    return r;
  endfunction

endpackage

### rtl/core/meos_ram.sv
// meos_ram: generic single-port-write, single-port-read ram with registered read
// no dependencies
module meos_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

### rtl/core/midi_event_ordering_sorter.sv
// midi_event_ordering_sorter: sorted event table in one ram, insertion by scan and shift
// insert: the input stalls while the insert runs (scan one entry per cycle, then shift down
// one entry at a time, read then write); a flush reads each entry and registers it as a
// request, holding while out_stall is high
// throughput: one request at a time; the table ram sets the pace
// reset: count and overflow clear, ram contents left undefined; needs meos_pkg, meos_ram
module midi_event_ordering_sorter
  import meos_pkg::*;
#(
  parameter int EVENT_SLOTS = 64
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  meos_in_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output meos_out_t out_data
);
  localparam int AW = $clog2(EVENT_SLOTS);
  localparam int CW = $clog2(EVENT_SLOTS + 1);
  localparam logic [CW-1:0] FULL = CW'(EVENT_SLOTS);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_SCAN  = 3'd1;
  localparam logic [2:0] S_SHIFT = 3'd2;
  localparam logic [2:0] S_FLUSH = 3'd3;
  localparam logic [2:0] S_OUT   = 3'd4;

  logic [2:0]    state_r, state_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic          ovf_r, ovf_nxt;
  logic [CW-1:0] idx_r, idx_nxt;
  logic          rd_pend_r, rd_pend_nxt;
  meos_slot_t    ev_r, ev_nxt;
  logic [CW-1:0] pos_r, pos_nxt;
  logic          ov_r, ov_nxt;
  meos_out_t     od_r, od_nxt;

  logic          we;
  logic [AW-1:0] waddr, raddr;
  meos_slot_t    wdata, rdata;
  logic [SLOT_W-1:0] rraw;

  meos_ram #(.WIDTH(SLOT_W), .DEPTH(EVENT_SLOTS)) u_table (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rraw)
  );
  assign rdata = meos_slot_t'(rraw);

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = ov_r;
  assign out_data  = od_r;

  always_comb begin
    state_nxt = state_r; count_nxt = count_r; ovf_nxt = ovf_r; idx_nxt = idx_r;
    rd_pend_nxt = 1'b0; ev_nxt = ev_r; pos_nxt = pos_r; ov_nxt = ov_r; od_nxt = od_r;
    we = 1'b0; waddr = '0; wdata = ev_r; raddr = idx_r[AW-1:0];
    if (ov_r && !out_stall) ov_nxt = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          idx_nxt = '0;
          if (in_data.opcode == OP_FLUSH) begin
            if (count_r != '0) state_nxt = S_FLUSH;
          end else if (in_data.byte_count <= 4'd3) begin
            ev_nxt.t  = in_data.event_time;
            ev_nxt.st = (in_data.byte_count > 4'd0) ? in_data.status_byte : 8'd0;
            ev_nxt.d1 = (in_data.byte_count > 4'd1) ? in_data.first_data : 8'd0;
            ev_nxt.d2 = (in_data.byte_count > 4'd2) ? in_data.second_data : 8'd0;
            state_nxt = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        // rd_pend_r means rdata holds entry idx_r-1
        if (rd_pend_r && sort_key(rdata) == sort_key(ev_r)) begin
          state_nxt = S_IDLE;
        end else if ((rd_pend_r && sort_key(rdata) > sort_key(ev_r)) ||
                     (!rd_pend_r && idx_r == count_r)) begin
          if (count_r == FULL) begin
            ovf_nxt = 1'b1;
            state_nxt = S_IDLE;
          end else begin
            pos_nxt = rd_pend_r ? idx_r - 1'b1 : idx_r;
            idx_nxt = count_r;
            state_nxt = S_SHIFT;
          end
        end else if (rd_pend_r && idx_r == count_r) begin
          idx_nxt = idx_r;
        end else begin
          idx_nxt = idx_r + 1'b1;
          rd_pend_nxt = 1'b1;
        end
        if (rd_pend_r && idx_r == count_r && sort_key(rdata) < sort_key(ev_r))
          rd_pend_nxt = 1'b0;
      end
      S_SHIFT: begin
        // move entry idx-1 to idx, reading one step ahead
        if (idx_r == pos_r) begin
          we = 1'b1; waddr = pos_r[AW-1:0]; wdata = ev_r;
          count_nxt = count_r + 1'b1;
          state_nxt = S_IDLE;
        end else if (!rd_pend_r) begin
          raddr = AW'(idx_r - 1'b1);
          rd_pend_nxt = 1'b1;
        end else begin
          we = 1'b1; waddr = idx_r[AW-1:0]; wdata = rdata;
          idx_nxt = idx_r - 1'b1;
        end
      end
      S_FLUSH: begin
        raddr = idx_r[AW-1:0];
        state_nxt = S_OUT;
      end
      S_OUT: begin
        if (!ov_r || !out_stall) begin
          ov_nxt = 1'b1;
          od_nxt.out_time = rdata.t;
          od_nxt.out_status = rdata.st;
          od_nxt.out_data1 = rdata.d1;
          od_nxt.out_data2 = rdata.d2;
          od_nxt.out_size = msg_size(rdata.st);
          od_nxt.is_last = (idx_r + 1'b1 == count_r);
          od_nxt.overflowed = ovf_r;
          if (idx_r + 1'b1 == count_r) begin
            count_nxt = '0;
            state_nxt = S_IDLE;
          end else begin
            idx_nxt = idx_r + 1'b1;
            state_nxt = S_FLUSH;
          end
        end else begin
          raddr = idx_r[AW-1:0];
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE; count_r <= '0; ovf_r <= 1'b0; ov_r <= 1'b0; rd_pend_r <= 1'b0;
    end else begin
      state_r <= state_nxt; count_r <= count_nxt; ovf_r <= ovf_nxt; ov_r <= ov_nxt;
      rd_pend_r <= rd_pend_nxt;
    end
    idx_r <= idx_nxt; ev_r <= ev_nxt; pos_r <= pos_nxt; od_r <= od_nxt;
  end
endmodule

### tb/sv/testbench.sv
// testbench for midi_event_ordering_sorter: random and directed insert/flush traffic,
// with flushed events checked against a sorted-table scoreboard
// depends on meos_pkg and the sorter rtl
module testbench;
  import meos_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int TABLE_DEPTH = 64;
  localparam int STALL_LIMIT = 5000;
  localparam int SETTLE_CYCLES = 150;
  localparam int IN_W = $bits(meos_in_t);

  class event_order_board;
    meos_slot_t  slots[TABLE_DEPTH];
    int unsigned held;
    bit          lost;
    meos_out_t   due[$];
    int          errors;
    bit [4:0]    class_order[8] = '{5'd8, 5'd9, 5'd20, 5'd4, 5'd6, 5'd16, 5'd18, 5'd0};

    function bit [48:0] order_key(meos_slot_t s);
      return {s.t, class_order[s.st[6:4]], s.st[3:0], s.d1};
    endfunction

    function bit [1:0] wire_length(bit [7:0] st);
      if (!st[7]) return 2'd0;
      if (st[7:4] == 4'hC || st[7:4] == 4'hD) return 2'd2;
      if (st[7:4] != 4'hF) return 2'd3;
      if (st == 8'hF1 || st == 8'hF3) return 2'd2;
      if (st == 8'hF2) return 2'd3;
      return 2'd1;
    endfunction

    function void note_request(meos_in_t r);
      meos_slot_t e;
      meos_out_t  o;
      int unsigned pos;
      if (r.opcode == OP_FLUSH) begin
        for (int unsigned i = 0; i < held; i++) begin
          o.out_time   = slots[i].t;
          o.out_status = slots[i].st;
          o.out_data1  = slots[i].d1;
          o.out_data2  = slots[i].d2;
          o.out_size   = wire_length(slots[i].st);
          o.is_last    = (i + 1 == held);
          o.overflowed = lost;
          due.push_back(o);
        end
        held = 0;
        return;
      end
      if (r.byte_count > 3) return;
      e.t  = r.event_time;
      e.st = r.byte_count > 0 ? r.status_byte : 8'h00;
      e.d1 = r.byte_count > 1 ? r.first_data : 8'h00;
      e.d2 = r.byte_count > 2 ? r.second_data : 8'h00;
      pos = 0;
      while (pos < held) begin
        if (order_key(slots[pos]) == order_key(e)) return;
        if (order_key(slots[pos]) > order_key(e)) break;
        pos++;
      end
      if (held >= TABLE_DEPTH) begin
        lost = 1;
        return;
      end
      for (int unsigned i = held; i > pos; i--) slots[i] = slots[i-1];
      slots[pos] = e;
      held++;
    endfunction

    function void check_result(meos_out_t got);
      meos_out_t want;
      if (due.size() == 0) begin
        $display("%0t unexpected event, expected none actual %p", $time, got);
        errors++;
        return;
      end
      want = due.pop_front();
      if (got.out_time !== want.out_time || got.out_status !== want.out_status ||
          got.out_data1 !== want.out_data1 || got.out_data2 !== want.out_data2 ||
          got.out_size !== want.out_size || got.is_last !== want.is_last ||
          got.overflowed !== want.overflowed) begin
        $display("%0t mismatch expected %p actual %p", $time, want, got);
        errors++;
      end
    endfunction
  endclass

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_stall;
  meos_in_t  in_data;
  logic      out_valid;
  logic      out_stall;
  meos_out_t out_data;

  event_order_board board;
  bit          sender_idles;
  bit          receiver_idles;
  bit          hold_start;
  bit          hold_done;
  int          quiet_cycles;
  meos_in_t    recent[$];

  midi_event_ordering_sorter dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
  );

  initial begin
    clk = 0;
    forever #4 clk = ~clk;
  end

  // receiver: random stalls plus one long hold-off
  initial begin
    out_stall = 0;
    forever begin
      @(negedge clk);
      if (hold_start && !hold_done) begin
        out_stall <= 1;
        repeat (400) @(negedge clk);
        hold_done = 1;
        out_stall <= 0;
      end else begin
        out_stall <= receiver_idles && ($urandom_range(99) < 29);
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) board.check_result(out_data);
    if (rst_n && ((out_valid && !out_stall) || (in_valid && !in_stall)))
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  task automatic send(meos_in_t r);
    @(negedge clk);
    while (sender_idles && $urandom_range(99) < 29) begin
      in_valid <= 0;
      @(negedge clk);
    end
    in_valid <= 1;
    in_data  <= r;
    do @(posedge clk); while (in_stall);
    board.note_request(r);
  endtask

  task automatic put_event(bit [31:0] t, bit [7:0] st, bit [7:0] d1, bit [7:0] d2,
                           bit [3:0] n);
    meos_in_t r;
    r.opcode = OP_INSERT;
    r.event_time = t;
    r.status_byte = st;
    r.first_data = d1;
    r.second_data = d2;
    r.byte_count = n;
    send(r);
    recent.push_back(r);
    if (recent.size() > 16) void'(recent.pop_front());
  endtask

  task automatic flush_table();
    meos_in_t r;
    r = meos_in_t'(IN_W'({$urandom, $urandom}));
    r.opcode = OP_FLUSH;
    send(r);
  endtask

  task automatic drain();
    @(negedge clk);
    in_valid <= 0;
    while (board.due.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic random_event();
    meos_in_t r;
    int pick;
    pick = $urandom_range(99);
    if (pick < 15 && recent.size() > 0) begin
      r = recent[$urandom_range(recent.size() - 1)];
      r.second_data = 8'($urandom);
      send(r);
    end else begin
      put_event($urandom_range(1) ? 32'($urandom_range(7)) : 32'($urandom), 8'($urandom),
                $urandom_range(1) ? 8'($urandom_range(3)) : 8'($urandom), 8'($urandom),
                pick < 25 ? 4'($urandom_range(2)) : 4'd3);
    end
  endtask

  initial begin
    int items;
    int batch;
    int overflow_batches;
    meos_in_t junk;
    board = new();
    rst_n = 0;
    in_valid = 0;
    in_data = '0;
    sender_idles = 1;
    receiver_idles = 1;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1;

    // directed
    flush_table();
    put_event(32'hFFFF_FFFF, 8'hFF, 8'hFF, 8'hFF, 4'd3);
    put_event(32'd0, 8'h90, 8'h3C, 8'h7F, 4'd3);
    put_event(32'd0, 8'hB0, 8'h00, 8'h10, 4'd3);
    put_event(32'd0, 8'hC0, 8'h05, 8'hAA, 4'd2);
    put_event(32'd0, 8'h80, 8'h3C, 8'h40, 4'd3);
    put_event(32'd0, 8'hA3, 8'h3C, 8'h40, 4'd3);
    put_event(32'd0, 8'hD1, 8'h22, 8'h33, 4'd1);
    put_event(32'd0, 8'hE2, 8'h01, 8'h02, 4'd3);
    put_event(32'd0, 8'hF0, 8'h01, 8'h02, 4'd3);
    put_event(32'd1, 8'hF1, 8'h11, 8'h12, 4'd3);
    put_event(32'd1, 8'hF2, 8'h11, 8'h12, 4'd3);
    put_event(32'd1, 8'hF3, 8'h11, 8'h12, 4'd3);
    put_event(32'd2, 8'h45, 8'h66, 8'h77, 4'd0);
    put_event(32'd2, 8'h45, 8'h66, 8'h77, 4'd3);
    put_event(32'd0, 8'h90, 8'h3C, 8'h01, 4'd3);
    put_event(32'd5, 8'h90, 8'h3C, 8'h01, 4'd4);
    put_event(32'd5, 8'h90, 8'h3C, 8'h01, 4'd15);
    flush_table();
    flush_table();
    drain();

    // random
    items = 0;
    overflow_batches = 0;
    while (items < 360) begin
      if (items >= 150 && items < 230) begin
        sender_idles = 0;
        receiver_idles = 0;
      end else begin
        sender_idles = 1;
        receiver_idles = 1;
      end
      case ($urandom_range(9))
        0: batch = 0;
        1: batch = overflow_batches < 2 ? 70 : 10;
        default: batch = $urandom_range(1, 20);
      endcase
      if (batch == 70) overflow_batches++;
      for (int i = 0; i < batch; i++) begin
        if ($urandom_range(9) == 0) begin
          junk = meos_in_t'(IN_W'({$urandom, $urandom}));
          junk.opcode = OP_INSERT;
          junk.byte_count = 4'($urandom_range(4, 15));
          send(junk);
        end
        random_event();
        items++;
      end
      if (!hold_start && board.held >= 20) hold_start = 1;
      flush_table();
      items++;
      if ($urandom_range(15) == 0) drain();
    end
    drain();

    if (board.errors == 0 && board.due.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
